// ----- src/sssd_pkg.sv -----
// shared types, constants and the segment code table of the seven-segment scan driver
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package sssd_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned RpmW   = 14;
  localparam int unsigned SpeedW = 8;
  localparam int unsigned EnW    = 4;
  localparam int unsigned DigitW = 4;
  localparam int unsigned NumDigits = 4;
  localparam int unsigned CntW   = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_SHOW   = 2'd0,
    CMD_TOGGLE = 2'd1,
    CMD_BLANK  = 2'd2
  } cmd_e;

  typedef logic [DigitW-1:0] digit_t;

  typedef struct packed {
    logic                        blank;
    logic                        box;
    logic [NumDigits-1:0][DigitW-1:0] digits;
  } entry_t;

  localparam logic [6:0] SegOff = 7'h7f;

  function automatic logic [6:0] seg_code(input digit_t d);
    logic [6:0] s;
    case (d)
      4'd0: s = 7'h40;
      4'd1: s = 7'h79;
      4'd2: s = 7'h24;
      4'd3: s = 7'h30;
      4'd4: s = 7'h19;
      4'd5: s = 7'h12;
      4'd6: s = 7'h02;
      4'd7: s = 7'h78;
      4'd8: s = 7'h00;
      4'd9: s = 7'h10;
      default: s = SegOff;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- src/sssd_if.sv -----
// handshake interfaces for the command input and the serial bit output
// depends on sssd_pkg for field widths
`default_nettype none

interface sssd_in_if;
  logic                           valid;
  logic                           ready;
  logic [sssd_pkg::CmdW-1:0]      command;
  logic [sssd_pkg::RpmW-1:0]      rpm;
  logic [sssd_pkg::SpeedW-1:0]    speed;

  modport source (output valid, command, rpm, speed, input ready);
  modport sink (input valid, command, rpm, speed, output ready);
endinterface

interface sssd_out_if;
  logic                       valid;
  logic                       ready;
  logic [sssd_pkg::EnW-1:0]   digit_enable;
  logic                       serial_data;
  logic                       latch_pulse;
  logic                       last;

  modport source (output valid, digit_enable, serial_data, latch_pulse, last, input ready);
  modport sink (input valid, digit_enable, serial_data, latch_pulse, last, output ready);
endinterface

`default_nettype wire

// ----- src/seven_segment_scan_shift_driver_core.sv -----
// top level of the seven-segment scan driver for a serial-in latch register
// depends on sssd_pkg, sssd_if, sssd_front, sssd_queue and sssd_back
//
// in_i takes commands: show (rpm and speed as four digits), toggle box led, blank.
// out_o gives one transaction per shifted bit: digit enable, serial bit, latch
// strobe on the eighth bit of a frame, and last on the final bit of a command.
// show gives 32 bits (four frames), blank gives 8 bits with the held enable,
// toggle and the unused code give nothing; they are taken one per cycle while ready.
// a command passes the front register, the fifo and the current entry register of
// the scan engine before its first bit is registered onto out_o. the scan engine
// gives one bit per cycle while out_o is ready, back to back with no gap between commands.
// the front end and a QueueDepth-entry fifo keep taking commands while the
// scan engine is busy; in_i stalls once the fifo and the front register fill.
// when out_o stalls the current bit holds and the scan pauses.
// reset clears the box led bit, the held enable and all valid state.
`default_nettype none

module seven_segment_scan_shift_driver_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sssd_in_if.sink    in_i,
  sssd_out_if.source out_o
);

  sssd_pkg::entry_t push_data;
  logic             push_valid;
  logic             push_ready;
  sssd_pkg::entry_t pop_data;
  logic             pop_valid;
  logic             pop_ready;

  sssd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_data_o  (push_data),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  sssd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_data),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  sssd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_data_i  (pop_data),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ----- src/sssd_front.sv -----
// front end: accepts commands, keeps the box led bit, splits readings into digits
// depends on sssd_pkg and sssd_in_if; feeds entries to sssd_queue
`default_nettype none

module sssd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  sssd_in_if.sink            in_i,
  output sssd_pkg::entry_t   push_data_o,
  output logic               push_valid_o,
  input  wire logic          push_ready_i
);

  logic box_q, box_d;
  logic s1_valid_q, s1_valid_d;
  logic s1_blank_q;
  logic s1_box_q;
  logic [sssd_pkg::RpmW-1:0]   rpm_q;
  logic [4:0]                  kilo_q;
  logic [sssd_pkg::SpeedW-1:0] spd_q;
  logic [4:0]                  tens_q;

  logic                        acc;
  logic                        keep;
  logic [4:0]                  kilo_d;
  logic [15:0]                 spd_prod;
  logic [13:0]                 kilo_x1000;
  logic [9:0]                  rem;
  logic [3:0]                  hund;
  logic [7:0]                  tens_x10;
  logic [3:0]                  units;
  logic [3:0]                  thou;
  logic [3:0]                  tens;

  assign in_i.ready = !s1_valid_q || push_ready_i;
  assign acc  = in_i.valid && in_i.ready;
  assign keep = (in_i.command == sssd_pkg::CMD_SHOW) || (in_i.command == sssd_pkg::CMD_BLANK);

  // thousands count by threshold compare
  always_comb begin
    kilo_d = 5'd0;
    for (int i = 1; i <= 16; i++) begin
      if (in_i.rpm >= 14'(i * 1000)) begin
        kilo_d = 5'(i);
      end
    end
  end

  assign spd_prod = 16'(in_i.speed) * 16'd205;

  always_comb begin
    box_d = box_q;
    if (acc && (in_i.command == sssd_pkg::CMD_TOGGLE)) begin
      box_d = ~box_q;
    end
    s1_valid_d = s1_valid_q;
    if (acc) begin
      s1_valid_d = keep;
    end else if (push_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      box_q      <= box_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_blank_q <= (in_i.command == sssd_pkg::CMD_BLANK);
      s1_box_q   <= box_q;
      rpm_q      <= in_i.rpm;
      kilo_q     <= kilo_d;
      spd_q      <= in_i.speed;
      tens_q     <= spd_prod[15:11];
    end
  end

  // second stage: remainders and clamping
  assign kilo_x1000 = 14'(kilo_q) * 14'd1000;
  assign rem        = 10'(rpm_q - kilo_x1000);

  always_comb begin
    hund = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (rem >= 10'(i * 100)) begin
        hund = 4'(i);
      end
    end
  end

  assign tens_x10 = 8'({tens_q, 3'b000}) + 8'({tens_q, 1'b0});
  assign units    = 4'(spd_q - tens_x10);
  assign thou     = (kilo_q > 5'd9) ? 4'd9 : 4'(kilo_q);
  assign tens     = (tens_q > 5'd9) ? 4'd9 : 4'(tens_q);

  assign push_valid_o            = s1_valid_q;
  assign push_data_o.blank       = s1_blank_q;
  assign push_data_o.box         = s1_box_q;
  assign push_data_o.digits[0]   = thou;
  assign push_data_o.digits[1]   = hund;
  assign push_data_o.digits[2]   = tens;
  assign push_data_o.digits[3]   = units;

endmodule

`default_nettype wire

// ----- src/sssd_queue.sv -----
// short fifo of classified entries between the front end and the scan engine
// depends on sssd_pkg for the entry type
`default_nettype none

module sssd_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sssd_pkg::entry_t  push_data_i,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  output sssd_pkg::entry_t       pop_data_o,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  sssd_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             push, pop;

  assign push_ready_o = (fill_q != FillW'(Depth));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    fill_d = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/sssd_back.sv -----
// scan engine: walks frames bit by bit, drives digit enables and the latch strobe
// depends on sssd_pkg and sssd_out_if; pulls entries from sssd_queue
`default_nettype none

module sssd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sssd_pkg::entry_t  pop_data_i,
  input  wire logic              pop_valid_i,
  output logic                   pop_ready_o,
  sssd_out_if.source             out_o
);

  sssd_pkg::entry_t              cur_q;
  logic                          cur_valid_q, cur_valid_d;
  logic [sssd_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [sssd_pkg::EnW-1:0]      en_held_q, en_held_d;
  logic                          out_valid_q, out_valid_d;
  logic [sssd_pkg::EnW-1:0]      out_en_q;
  logic                          out_data_q;
  logic                          out_latch_q;
  logic                          out_last_q;

  logic                          emit;
  logic                          last_bit;
  logic                          done;
  logic                          pop;
  logic [1:0]                    dsel;
  logic [2:0]                    bsel;
  logic [sssd_pkg::EnW-1:0]      show_en;
  logic [sssd_pkg::EnW-1:0]      bit_en;
  logic [7:0]                    frame;

  assign dsel     = cnt_q[4:3];
  assign bsel     = cnt_q[2:0];
  assign emit     = cur_valid_q && (!out_valid_q || out_o.ready);
  assign last_bit = cur_q.blank ? (bsel == 3'd7) : (cnt_q == 5'd31);
  assign done     = emit && last_bit;
  assign pop      = pop_valid_i && (!cur_valid_q || done);
  assign pop_ready_o = !cur_valid_q || done;

  assign show_en = sssd_pkg::EnW'(1) << dsel;
  assign bit_en  = cur_q.blank ? en_held_q : show_en;
  assign frame   = cur_q.blank ? {cur_q.box, sssd_pkg::SegOff}
                               : {cur_q.box, sssd_pkg::seg_code(cur_q.digits[dsel])};

  always_comb begin
    cur_valid_d = cur_valid_q;
    cnt_d       = cnt_q;
    if (pop) begin
      cur_valid_d = 1'b1;
      cnt_d       = '0;
    end else if (done) begin
      cur_valid_d = 1'b0;
    end else if (emit) begin
      cnt_d = cnt_q + 1'b1;
    end
    en_held_d = en_held_q;
    if (emit && !cur_q.blank) begin
      en_held_d = show_en;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cnt_q       <= '0;
      en_held_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      cnt_q       <= cnt_d;
      en_held_q   <= en_held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= pop_data_i;
    end
    if (emit) begin
      out_en_q    <= bit_en;
      out_data_q  <= frame[3'd7 - bsel];
      out_latch_q <= (bsel == 3'd7);
      out_last_q  <= last_bit;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.digit_enable = out_en_q;
  assign out_o.serial_data  = out_data_q;
  assign out_o.latch_pulse  = out_latch_q;
  assign out_o.last         = out_last_q;

endmodule

`default_nettype wire
